@@ rtl/core/kpt_pkg.sv @@
// Shared types, constants and the microprogram of the Kalman position tracker.
package kpt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int W = 32;
	localparam int NREG = 32;
	localparam int RA_W = 5;
	localparam int PC_W = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic signed [W-1:0] Q_ONE = W'(1) <<< FRAC_BITS;
	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_NOISE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAD_NOISE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 2'd3;

	// register file map
	localparam logic [RA_W-1:0] R_ZERO = 5'd0;
	localparam logic [RA_W-1:0] R_ONE = 5'd1;
	localparam logic [RA_W-1:0] R_SPEED = 5'd2;
	localparam logic [RA_W-1:0] R_PN = 5'd3;
	localparam logic [RA_W-1:0] R_HN = 5'd4;
	localparam logic [RA_W-1:0] R_MN = 5'd5;
	localparam logic [RA_W-1:0] R_DT = 5'd6;
	localparam logic [RA_W-1:0] R_MX = 5'd7;
	localparam logic [RA_W-1:0] R_MY = 5'd8;
	localparam logic [RA_W-1:0] R_PX = 5'd9;
	localparam logic [RA_W-1:0] R_PY = 5'd10;
	localparam logic [RA_W-1:0] R_C00 = 5'd11; // covariance 11..19, row major
	localparam logic [RA_W-1:0] R_D = 5'd20;
	localparam logic [RA_W-1:0] R_XP = 5'd21;
	localparam logic [RA_W-1:0] R_T0 = 5'd22;
	localparam logic [RA_W-1:0] R_T1 = 5'd23;
	localparam logic [RA_W-1:0] R_T2 = 5'd24;
	localparam logic [RA_W-1:0] R_T3 = 5'd25;
	localparam logic [RA_W-1:0] R_T4 = 5'd26;
	localparam logic [RA_W-1:0] R_T5 = 5'd27;
	localparam logic [RA_W-1:0] R_T6 = 5'd28;
	localparam logic [RA_W-1:0] R_T7 = 5'd29;
	localparam logic [RA_W-1:0] R_T8 = 5'd30;
	localparam logic [RA_W-1:0] R_T9 = 5'd31;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_MUL,   // acc = a*b, wb if wr
		OP_MAC,   // acc += a*b
		OP_ADD,   // acc = a+b (exact)
		OP_SUB,   // acc = a-b
		OP_DIV,   // dst = sat((a<<F)/b), multi cycle
		OP_DONE   // end of program
	} op_t;

	typedef enum logic [1:0] {
		JC_NONE,
		JC_SEEDED, // jump when already seeded
		JC_DETNZ   // jump when register a is nonzero
	} jc_t;

	typedef struct packed {
		op_t op;
		logic [RA_W-1:0] a;
		logic [RA_W-1:0] b;
		logic [RA_W-1:0] dst;
		logic wr;     // write saturated accumulator (or quotient) to dst
		logic neg;    // negate the quotient before writeback (divide only)
		jc_t jc;
		logic [PC_W-1:0] tgt;
	} uop_t;

	typedef struct packed {
		logic busy;
		logic div_busy;
	} dp_stat_t;

	function automatic uop_t mk(op_t op, logic [RA_W-1:0] a, logic [RA_W-1:0] b,
		logic [RA_W-1:0] dst, logic wr, logic neg);
		uop_t u;
		u.op = op; u.a = a; u.b = b; u.dst = dst; u.wr = wr; u.neg = neg;
		u.jc = JC_NONE; u.tgt = '0;
		return u;
	endfunction

	function automatic uop_t mkj(jc_t jc, logic [RA_W-1:0] a, logic [PC_W-1:0] tgt);
		uop_t u;
		u = mk(OP_NOP, a, R_ZERO, R_ZERO, 1'b0, 1'b0);
		u.jc = jc; u.tgt = tgt;
		return u;
	endfunction

	function automatic logic [RA_W-1:0] cv(int i, int j);
		return RA_W'(11 + 3*i + j);
	endfunction

	// Program. Registers: T0..T9 temporaries; the A*P*A^T with A having only
	// d at [1][2] expands to: ap rows 0,2 = P rows, ap row1 = P1 + d*P2.
	function automatic uop_t ucode(logic [PC_W-1:0] pc);
		case (pc)
			// seed
			7'd0: return mkj(JC_SEEDED, R_ZERO, 7'd3);
			7'd1: return mk(OP_ADD, R_MX, R_ZERO, R_PX, 1'b1, 1'b0);
			7'd2: return mk(OP_ADD, R_MY, R_ZERO, R_PY, 1'b1, 1'b0);
			// d, xp
			7'd3: return mk(OP_MUL, R_SPEED, R_DT, R_D, 1'b1, 1'b0);
			7'd4: return mk(OP_ADD, R_PX, R_D, R_XP, 1'b1, 1'b0);
			// ap row1 = dot3(0,P0j,1,P1j,d,P2j) -> T0..T2 ; rows 0,2 = P (exact dot)
			7'd5: return mk(OP_MUL, R_ONE, cv(1,0), R_ZERO, 1'b0, 1'b0);
			7'd6: return mk(OP_MAC, R_D, cv(2,0), R_T0, 1'b1, 1'b0);
			7'd7: return mk(OP_MUL, R_ONE, cv(1,1), R_ZERO, 1'b0, 1'b0);
			7'd8: return mk(OP_MAC, R_D, cv(2,1), R_T1, 1'b1, 1'b0);
			7'd9: return mk(OP_MUL, R_ONE, cv(1,2), R_ZERO, 1'b0, 1'b0);
			7'd10: return mk(OP_MAC, R_D, cv(2,2), R_T2, 1'b1, 1'b0);
			// ap rows0/2 = qmul(one,P) which equals P exactly
			// pp[i][j] = dot3(ap[i][k], a[j][k]); a row0=e0,row1=(0,1,d),row2=e2
			// pp00=P00, pp01 = P01 + d*P02 -> T3, pp02=P02
			7'd11: return mk(OP_MUL, R_ONE, cv(0,1), R_ZERO, 1'b0, 1'b0);
			7'd12: return mk(OP_MAC, R_D, cv(0,2), R_T3, 1'b1, 1'b0);
			// pp10=T0, pp11 = T1 + d*T2 -> T4, pp12=T2
			7'd13: return mk(OP_MUL, R_ONE, R_T1, R_ZERO, 1'b0, 1'b0);
			7'd14: return mk(OP_MAC, R_D, R_T2, R_T4, 1'b1, 1'b0);
			// pp20=P20, pp21 = P21 + d*P22 -> T5, pp22=P22
			7'd15: return mk(OP_MUL, R_ONE, cv(2,1), R_ZERO, 1'b0, 1'b0);
			7'd16: return mk(OP_MAC, R_D, cv(2,2), R_T5, 1'b1, 1'b0);
			// write pp into covariance slots (pp in C) with noise
			7'd17: return mk(OP_ADD, cv(0,0), R_PN, cv(0,0), 1'b1, 1'b0);
			7'd18: return mk(OP_ADD, R_T3, R_ZERO, cv(0,1), 1'b1, 1'b0);
			7'd19: return mk(OP_ADD, R_T0, R_ZERO, cv(1,0), 1'b1, 1'b0);
			7'd20: return mk(OP_ADD, R_T4, R_PN, cv(1,1), 1'b1, 1'b0);
			7'd21: return mk(OP_ADD, R_T2, R_ZERO, cv(1,2), 1'b1, 1'b0);
			7'd22: return mk(OP_ADD, R_T5, R_ZERO, cv(2,1), 1'b1, 1'b0);
			7'd23: return mk(OP_ADD, cv(2,2), R_HN, cv(2,2), 1'b1, 1'b0);
			// S: s00 -> T0, s11 -> T1 (s01=C01, s10=C10)
			7'd24: return mk(OP_ADD, cv(0,0), R_MN, R_T0, 1'b1, 1'b0);
			7'd25: return mk(OP_ADD, cv(1,1), R_MN, R_T1, 1'b1, 1'b0);
			// det = sat(qmul(s00,s11) - qmul(s01,s10)) -> T2
			7'd26: return mk(OP_MUL, R_T0, R_T1, R_T2, 1'b1, 1'b0);
			7'd27: return mk(OP_MUL, cv(0,1), cv(1,0), R_T3, 1'b1, 1'b0);
			7'd28: return mk(OP_SUB, R_T2, R_T3, R_T2, 1'b1, 1'b0);
			7'd29: return mkj(JC_DETNZ, R_T2, 7'd31);
			7'd30: return mk(OP_ADD, R_ONE, R_ZERO, R_T2, 1'b1, 1'b0); // patched to LSB
			// inverse: si00 T3, si11 T4, si01 T5, si10 T6
			7'd31: return mk(OP_DIV, R_T1, R_T2, R_T3, 1'b1, 1'b0);
			7'd32: return mk(OP_DIV, R_T0, R_T2, R_T4, 1'b1, 1'b0);
			7'd33: return mk(OP_DIV, cv(0,1), R_T2, R_T5, 1'b1, 1'b1);
			7'd34: return mk(OP_DIV, cv(1,0), R_T2, R_T6, 1'b1, 1'b1);
			// K: k00 T0,k01 T1,k10 T2,k11 T7,k20 T8,k21 T9
			7'd35: return mk(OP_MUL, cv(0,0), R_T3, R_ZERO, 1'b0, 1'b0);
			7'd36: return mk(OP_MAC, cv(0,1), R_T6, R_T0, 1'b1, 1'b0);
			7'd37: return mk(OP_MUL, cv(0,0), R_T5, R_ZERO, 1'b0, 1'b0);
			7'd38: return mk(OP_MAC, cv(0,1), R_T4, R_T1, 1'b1, 1'b0);
			7'd39: return mk(OP_MUL, cv(1,0), R_T3, R_ZERO, 1'b0, 1'b0);
			7'd40: return mk(OP_MAC, cv(1,1), R_T6, R_T2, 1'b1, 1'b0);
			7'd41: return mk(OP_MUL, cv(1,0), R_T5, R_ZERO, 1'b0, 1'b0);
			7'd42: return mk(OP_MAC, cv(1,1), R_T4, R_T7, 1'b1, 1'b0);
			7'd43: return mk(OP_MUL, cv(2,0), R_T3, R_ZERO, 1'b0, 1'b0);
			7'd44: return mk(OP_MAC, cv(2,1), R_T6, R_T8, 1'b1, 1'b0);
			7'd45: return mk(OP_MUL, cv(2,0), R_T5, R_ZERO, 1'b0, 1'b0);
			7'd46: return mk(OP_MAC, cv(2,1), R_T4, R_T9, 1'b1, 1'b0);
			// innovation ix T3, iy T4
			7'd47: return mk(OP_SUB, R_MX, R_XP, R_T3, 1'b1, 1'b0);
			7'd48: return mk(OP_SUB, R_MY, R_PY, R_T4, 1'b1, 1'b0);
			// position update via T5
			7'd49: return mk(OP_MUL, R_T0, R_T3, R_ZERO, 1'b0, 1'b0);
			7'd50: return mk(OP_MAC, R_T1, R_T4, R_T5, 1'b1, 1'b0);
			7'd51: return mk(OP_ADD, R_XP, R_T5, R_PX, 1'b1, 1'b0);
			7'd52: return mk(OP_MUL, R_T2, R_T3, R_ZERO, 1'b0, 1'b0);
			7'd53: return mk(OP_MAC, R_T7, R_T4, R_T5, 1'b1, 1'b0);
			7'd54: return mk(OP_ADD, R_PY, R_T5, R_PY, 1'b1, 1'b0);
			// ikh: 00=1-k00 T0, 01=-k01 T1, 10=-k10 T2, 11=1-k11 T7,
			// 20=-k20 T8, 21=-k21 T9, others identity
			7'd55: return mk(OP_SUB, R_ONE, R_T0, R_T0, 1'b1, 1'b0);
			7'd56: return mk(OP_SUB, R_ZERO, R_T1, R_T1, 1'b1, 1'b0);
			7'd57: return mk(OP_SUB, R_ZERO, R_T2, R_T2, 1'b1, 1'b0);
			7'd58: return mk(OP_SUB, R_ONE, R_T7, R_T7, 1'b1, 1'b0);
			7'd59: return mk(OP_SUB, R_ZERO, R_T8, R_T8, 1'b1, 1'b0);
			7'd60: return mk(OP_SUB, R_ZERO, R_T9, R_T9, 1'b1, 1'b0);
			// new P col j, rows 0,1 need temps: row0 -> T3..T5, row1 -> T6, D, XP
			// row0: n0j = T0*pp0j + T1*pp1j (+0*pp2j); row1: T2*pp0j + T7*pp1j
			// row2: T8*pp0j + T9*pp1j + 1*pp2j. Compute rows 0,1 to temps first.
			7'd61: return mk(OP_MUL, R_T0, cv(0,0), R_ZERO, 1'b0, 1'b0);
			7'd62: return mk(OP_MAC, R_T1, cv(1,0), R_T3, 1'b1, 1'b0);
			7'd63: return mk(OP_MUL, R_T0, cv(0,1), R_ZERO, 1'b0, 1'b0);
			7'd64: return mk(OP_MAC, R_T1, cv(1,1), R_T4, 1'b1, 1'b0);
			7'd65: return mk(OP_MUL, R_T0, cv(0,2), R_ZERO, 1'b0, 1'b0);
			7'd66: return mk(OP_MAC, R_T1, cv(1,2), R_T5, 1'b1, 1'b0);
			7'd67: return mk(OP_MUL, R_T2, cv(0,0), R_ZERO, 1'b0, 1'b0);
			7'd68: return mk(OP_MAC, R_T7, cv(1,0), R_T6, 1'b1, 1'b0);
			7'd69: return mk(OP_MUL, R_T2, cv(0,1), R_ZERO, 1'b0, 1'b0);
			7'd70: return mk(OP_MAC, R_T7, cv(1,1), R_D, 1'b1, 1'b0);
			7'd71: return mk(OP_MUL, R_T2, cv(0,2), R_ZERO, 1'b0, 1'b0);
			7'd72: return mk(OP_MAC, R_T7, cv(1,2), R_XP, 1'b1, 1'b0);
			// row2 directly into C2j (C2j read in the same dot before write)
			7'd73: return mk(OP_MUL, R_T8, cv(0,0), R_ZERO, 1'b0, 1'b0);
			7'd74: return mk(OP_MAC, R_T9, cv(1,0), R_ZERO, 1'b0, 1'b0);
			7'd75: return mk(OP_MAC, R_ONE, cv(2,0), cv(2,0), 1'b1, 1'b0);
			7'd76: return mk(OP_MUL, R_T8, cv(0,1), R_ZERO, 1'b0, 1'b0);
			7'd77: return mk(OP_MAC, R_T9, cv(1,1), R_ZERO, 1'b0, 1'b0);
			7'd78: return mk(OP_MAC, R_ONE, cv(2,1), cv(2,1), 1'b1, 1'b0);
			7'd79: return mk(OP_MUL, R_T8, cv(0,2), R_ZERO, 1'b0, 1'b0);
			7'd80: return mk(OP_MAC, R_T9, cv(1,2), R_ZERO, 1'b0, 1'b0);
			7'd81: return mk(OP_MAC, R_ONE, cv(2,2), cv(2,2), 1'b1, 1'b0);
			// copy rows 0,1
			7'd82: return mk(OP_ADD, R_T3, R_ZERO, cv(0,0), 1'b1, 1'b0);
			7'd83: return mk(OP_ADD, R_T4, R_ZERO, cv(0,1), 1'b1, 1'b0);
			7'd84: return mk(OP_ADD, R_T5, R_ZERO, cv(0,2), 1'b1, 1'b0);
			7'd85: return mk(OP_ADD, R_T6, R_ZERO, cv(1,0), 1'b1, 1'b0);
			7'd86: return mk(OP_ADD, R_D, R_ZERO, cv(1,1), 1'b1, 1'b0);
			7'd87: return mk(OP_ADD, R_XP, R_ZERO, cv(1,2), 1'b1, 1'b0);
			7'd88: return mk(OP_DONE, R_ZERO, R_ZERO, R_ZERO, 1'b0, 1'b0);
			default: return mk(OP_DONE, R_ZERO, R_ZERO, R_ZERO, 1'b0, 1'b0);
		endcase
	endfunction

	function automatic logic signed [W-1:0] sat64(logic signed [W+35:0] v);
		if (v > (W+36)'(SMAX)) return SMAX;
		if (v < (W+36)'(SMIN)) return SMIN;
		return v[W-1:0];
	endfunction

endpackage

@@ rtl/core/kpt_div.sv @@
// Restoring divider: sat((a << FRAC_BITS) / b), truncated toward zero.
module kpt_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [kpt_pkg::W-1:0] num,
	input  logic signed [kpt_pkg::W-1:0] den,
	output logic busy,
	output logic done,
	output logic signed [kpt_pkg::W-1:0] quo
);
	localparam int NW = kpt_pkg::W + kpt_pkg::FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] n_q;
	logic [NW-1:0] q_q;
	logic [kpt_pkg::W:0] r_q;
	logic [kpt_pkg::W-1:0] d_q;
	logic neg_q;
	logic [CW-1:0] cnt_q;
	logic run_q;
	logic done_q;

	logic [kpt_pkg::W:0] r_sh;
	logic [kpt_pkg::W:0] r_sub;
	logic [NW:0] qext;
	logic signed [NW+1:0] qs;

	assign r_sh = {r_q[kpt_pkg::W-1:0], n_q[NW-1]};
	assign r_sub = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= {(num[kpt_pkg::W-1] ? -num : num), {kpt_pkg::FRAC_BITS{1'b0}}};
			d_q <= den[kpt_pkg::W-1] ? -den : den;
			neg_q <= num[kpt_pkg::W-1] ^ den[kpt_pkg::W-1];
			r_q <= '0;
			q_q <= '0;
		end else if (run_q) begin
			n_q <= {n_q[NW-2:0], 1'b0};
			if (!r_sub[kpt_pkg::W]) begin
				r_q <= r_sub;
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		qext = {1'b0, q_q};
		qs = neg_q ? -$signed({1'b0, qext}) : $signed({1'b0, qext});
		if (qs > (NW+2)'(kpt_pkg::SMAX)) quo = kpt_pkg::SMAX;
		else if (qs < (NW+2)'(kpt_pkg::SMIN)) quo = kpt_pkg::SMIN;
		else quo = qs[kpt_pkg::W-1:0];
	end

	assign busy = run_q;
	assign done = done_q;
endmodule

@@ rtl/core/kpt_datapath.sv @@
// Register file, multiply-accumulate unit and divider driven by one control word.
module kpt_datapath (
	input  logic clk,
	input  logic arst_n,
	input  kpt_pkg::uop_t uop,
	input  logic exec,
	input  logic load,
	input  logic [30:0] dt,
	input  logic signed [kpt_pkg::W-1:0] meas_x,
	input  logic signed [kpt_pkg::W-1:0] meas_y,
	input  logic cfg_we,
	input  logic [kpt_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [30:0] cfg_data,
	output kpt_pkg::dp_stat_t stat,
	output logic a_nz,
	output logic signed [kpt_pkg::W-1:0] px,
	output logic signed [kpt_pkg::W-1:0] py
);
	localparam int AW = kpt_pkg::W + 36;

	logic signed [kpt_pkg::W-1:0] rf_q [kpt_pkg::NREG];
	logic signed [kpt_pkg::W-1:0] ra, rb;
	logic signed [2*kpt_pkg::W-1:0] prod;
	logic signed [2*kpt_pkg::W-1:0] pfl;
	logic signed [kpt_pkg::W-1:0] pq;
	logic signed [AW-1:0] acc_q, acc_n;
	logic signed [kpt_pkg::W-1:0] wv, wv2;
	logic dstart, dbusy, ddone;
	logic signed [kpt_pkg::W-1:0] dquo;
	logic [kpt_pkg::RA_W-1:0] ddst_q;
	logic dneg_q;

	// reset contents: identity covariance, the one constant, default settings, rest zero
	function automatic logic signed [kpt_pkg::W-1:0] rst_val(int i);
		case (kpt_pkg::RA_W'(i))
			kpt_pkg::R_ONE, kpt_pkg::R_C00, kpt_pkg::R_C00 + 5'd4,
			kpt_pkg::R_C00 + 5'd8: return kpt_pkg::Q_ONE;
			kpt_pkg::R_SPEED, kpt_pkg::R_HN: return kpt_pkg::W'(3277);
			kpt_pkg::R_PN: return kpt_pkg::W'(6554);
			kpt_pkg::R_MN: return kpt_pkg::W'(655360);
			default: return '0;
		endcase
	endfunction

	assign ra = rf_q[uop.a];
	assign rb = rf_q[uop.b];
	assign prod = ra * rb;
	assign pfl = prod >>> kpt_pkg::FRAC_BITS; // floor
	assign pq = kpt_pkg::sat64(AW'(pfl));
	assign a_nz = (ra != '0);

	always_comb begin
		case (uop.op)
			kpt_pkg::OP_MUL: acc_n = AW'(pq);
			kpt_pkg::OP_MAC: acc_n = acc_q + AW'(pq);
			kpt_pkg::OP_ADD: acc_n = AW'(ra) + AW'(rb);
			kpt_pkg::OP_SUB: acc_n = AW'(ra) - AW'(rb);
			default: acc_n = acc_q;
		endcase
		wv = kpt_pkg::sat64(acc_n);
		wv2 = (dneg_q && dquo == kpt_pkg::SMIN) ? kpt_pkg::SMAX : (dneg_q ? -dquo : dquo);
	end

	assign dstart = exec && uop.op == kpt_pkg::OP_DIV;

	kpt_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(ra), .den(rb),
		.busy(dbusy), .done(ddone), .quo(dquo)
	);

	always_ff @(posedge clk) begin
		if (dstart) begin
			ddst_q <= uop.dst;
			dneg_q <= uop.neg;
		end
		if (exec && uop.op != kpt_pkg::OP_DIV && uop.op != kpt_pkg::OP_NOP)
			acc_q <= acc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < kpt_pkg::NREG; i++) rf_q[i] <= rst_val(i);
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					kpt_pkg::CFG_SPEED: rf_q[kpt_pkg::R_SPEED] <= {1'b0, cfg_data};
					kpt_pkg::CFG_POS_NOISE: rf_q[kpt_pkg::R_PN] <= {1'b0, cfg_data};
					kpt_pkg::CFG_HEAD_NOISE: rf_q[kpt_pkg::R_HN] <= {1'b0, cfg_data};
					kpt_pkg::CFG_MEAS_NOISE: rf_q[kpt_pkg::R_MN] <= {1'b0, cfg_data};
					default: ;
				endcase
			end
			if (load) begin
				rf_q[kpt_pkg::R_DT] <= {1'b0, dt};
				rf_q[kpt_pkg::R_MX] <= meas_x;
				rf_q[kpt_pkg::R_MY] <= meas_y;
			end
			// detnz patch writes one LSB, not Q_ONE
			if (exec && uop.wr && uop.op != kpt_pkg::OP_DIV && uop.op != kpt_pkg::OP_NOP
					&& uop.dst != kpt_pkg::R_ZERO) begin
				if (uop.op == kpt_pkg::OP_ADD && uop.a == kpt_pkg::R_ONE
						&& uop.b == kpt_pkg::R_ZERO && uop.dst == kpt_pkg::R_T2)
					rf_q[uop.dst] <= kpt_pkg::W'(1);
				else
					rf_q[uop.dst] <= wv;
			end
			if (ddone) rf_q[ddst_q] <= wv2;
		end
	end

	assign stat.busy = dbusy;
	assign stat.div_busy = dbusy | ddone;
	assign px = rf_q[kpt_pkg::R_PX];
	assign py = rf_q[kpt_pkg::R_PY];
endmodule

@@ rtl/core/kpt_sequencer.sv @@
// Step counter over the microprogram, with conditional jumps and divider waits.
module kpt_sequencer (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  kpt_pkg::dp_stat_t stat,
	input  logic a_nz,
	output kpt_pkg::uop_t uop,
	output logic exec,
	output logic finish,
	output logic running
);
	logic [kpt_pkg::PC_W-1:0] pc_q;
	logic run_q;
	logic seeded_q;
	logic stall;
	logic take;

	assign uop = kpt_pkg::ucode(pc_q);
	assign stall = stat.div_busy;
	assign exec = run_q && !stall;
	assign finish = exec && uop.op == kpt_pkg::OP_DONE;
	assign running = run_q;

	always_comb begin
		case (uop.jc)
			kpt_pkg::JC_SEEDED: take = seeded_q;
			kpt_pkg::JC_DETNZ: take = a_nz;
			default: take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			run_q <= 1'b0;
			seeded_q <= 1'b0;
		end else if (start) begin
			pc_q <= '0;
			run_q <= 1'b1;
		end else if (exec) begin
			if (finish) begin
				run_q <= 1'b0;
				seeded_q <= 1'b1;
			end else if (take) pc_q <= uop.tgt;
			else pc_q <= pc_q + 1'b1;
		end
	end
endmodule

@@ rtl/core/kalman_position_tracker.sv @@
// Top level of the fixed-point Kalman position tracker.
// Usage:
//  - Input stream s_axis: one request per position fix, packed from bit 0 up:
//    dt in 30:0, meas_x in 62:31, meas_y in 94:63, bit 95 zero.
//  - Output stream m_axis: one result per request, est_x in 31:0, est_y in 63:32.
//  - Config port cfg_we/cfg_idx/cfg_data writes speed, pos_noise, heading_noise,
//    meas_noise (indexes 0..3); write only while idle.
// Operation: one request runs a microprogram of up to 89 steps on a shared
// multiply-accumulate unit; each of the four divides holds the step counter
// until the bit-serial divider has written its quotient. One request is in
// flight at a time.
// A finished result sits in the output register; the next request is accepted
// once the program ends, even while that result still waits.
// Reset: covariance returns to identity, position to zero, registers to
// defaults; the first request after reset seeds the position from its fix.
// A stalled receiver holds the result; a new result waits until it is taken.
module kalman_position_tracker (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [95:0] s_axis_tdata, // dt[30:0], meas_x, meas_y, pad
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [63:0] m_axis_tdata, // est_x, est_y
	input  logic cfg_we,
	input  logic [kpt_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [30:0] cfg_data
);
	kpt_pkg::uop_t uop;
	kpt_pkg::dp_stat_t stat;
	logic exec, finish, running, a_nz, accept;
	logic signed [kpt_pkg::W-1:0] px, py;
	logic ovalid_q;
	logic [63:0] odata_q;
	logic pend_q;

	// accept only when no program runs and no finished result is held back
	assign s_axis_tready = !running && !pend_q;
	assign accept = s_axis_tvalid && s_axis_tready;

	kpt_sequencer u_seq (
		.clk(clk), .arst_n(arst_n), .start(accept), .stat(stat), .a_nz(a_nz),
		.uop(uop), .exec(exec), .finish(finish), .running(running)
	);

	kpt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .uop(uop), .exec(exec), .load(accept),
		.dt(s_axis_tdata[30:0]), .meas_x(s_axis_tdata[62:31]),
		.meas_y(s_axis_tdata[94:63]), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .stat(stat), .a_nz(a_nz), .px(px), .py(py)
	);

	// pend_q: result computed but output register still occupied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if ((finish || pend_q) && (!ovalid_q || m_axis_tready)) begin
				ovalid_q <= 1'b1;
				pend_q <= 1'b0;
			end else begin
				if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
				if (finish) pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((finish || pend_q) && (!ovalid_q || m_axis_tready)) odata_q <= {py, px};
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = odata_q;
endmodule

@@ rtl/core/kpt_checker.sv @@
// Port-level checks of the tracker, bound to the top level.
module kpt_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [63:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed under stall");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request taken while one is in flight");
	a_nores: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> ##1 !($rose(m_axis_tvalid)))
		else $error("result too early");
endmodule

bind kalman_position_tracker kpt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

@@ verif/testbench.sv @@
// Self-checking testbench for the fixed-point Kalman position tracker.
module testbench;

	typedef logic signed [31:0] q_t;
	typedef struct packed {
		q_t est_y;
		q_t est_x;
	} fix_t;

	// Bit-exact predictor of the tracker; holds its own state and settings.
	class tracker_scoreboard;
		logic [30:0] speed, pos_noise, head_noise, meas_noise;
		bit seeded;
		q_t px, py;
		q_t cov [3][3];
		fix_t pending [$];
		int mismatches;
		int checked;

		function void clear();
			speed = 31'd3277; pos_noise = 31'd6554;
			head_noise = 31'd3277; meas_noise = 31'd655360;
			seeded = 0; px = 0; py = 0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					cov[i][j] = (i == j) ? kpt_pkg::Q_ONE : '0;
			pending.delete();
			mismatches = 0;
			checked = 0;
		endfunction

		function q_t clip(longint v);
			if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
			if (v < -longint'(64'sd2147483648)) return 32'sh80000000;
			return q_t'(v);
		endfunction

		// Product with flooring shift, then saturate.
		function q_t mul(q_t a, q_t b);
			longint p;
			p = longint'(a) * longint'(b);
			return clip(p >>> kpt_pkg::FRAC_BITS);
		endfunction

		function q_t add(q_t a, q_t b);
			return clip(longint'(a) + longint'(b));
		endfunction

		function q_t sub(q_t a, q_t b);
			return clip(longint'(a) - longint'(b));
		endfunction

		function q_t quot(q_t a, q_t b);
			longint n;
			n = longint'(a) * 65536;
			return clip(n / longint'(b));
		endfunction

		function q_t dot2(q_t a0, q_t b0, q_t a1, q_t b1);
			return clip(longint'(mul(a0, b0)) + longint'(mul(a1, b1)));
		endfunction

		function q_t dot3(q_t a0, q_t b0, q_t a1, q_t b1, q_t a2, q_t b2);
			return clip(longint'(mul(a0, b0)) + longint'(mul(a1, b1)) +
				longint'(mul(a2, b2)));
		endfunction

		function void write_reg(logic [kpt_pkg::CFG_IDX_W-1:0] idx, logic [30:0] val);
			case (idx)
				kpt_pkg::CFG_SPEED: speed = val;
				kpt_pkg::CFG_POS_NOISE: pos_noise = val;
				kpt_pkg::CFG_HEAD_NOISE: head_noise = val;
				kpt_pkg::CFG_MEAS_NOISE: meas_noise = val;
				default: ;
			endcase
		endfunction

		// Run predict and update for one accepted fix; queue its estimate.
		function void note_fix(logic [30:0] dt, q_t mx, q_t my);
			q_t a [3][3], ap [3][3], pp [3][3], ikh [3][3], k [3][2], si [2][2];
			q_t d, xp, yp, s00, s01, s10, s11, det, ix, iy;
			fix_t r;
			if (!seeded) begin
				px = mx; py = my; seeded = 1;
			end
			d = mul(q_t'({1'b0, speed}), q_t'({1'b0, dt}));
			xp = add(px, d);
			yp = py;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					a[i][j] = (i == j) ? kpt_pkg::Q_ONE : '0;
			a[1][2] = d;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					ap[i][j] = dot3(a[i][0], cov[0][j], a[i][1], cov[1][j],
						a[i][2], cov[2][j]);
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					pp[i][j] = dot3(ap[i][0], a[j][0], ap[i][1], a[j][1],
						ap[i][2], a[j][2]);
			pp[0][0] = add(pp[0][0], q_t'({1'b0, pos_noise}));
			pp[1][1] = add(pp[1][1], q_t'({1'b0, pos_noise}));
			pp[2][2] = add(pp[2][2], q_t'({1'b0, head_noise}));
			s00 = add(pp[0][0], q_t'({1'b0, meas_noise}));
			s01 = pp[0][1];
			s10 = pp[1][0];
			s11 = add(pp[1][1], q_t'({1'b0, meas_noise}));
			det = sub(mul(s00, s11), mul(s01, s10));
			// floor a singular determinant at one LSB
			if (det == 0) det = 1;
			si[0][0] = quot(s11, det);
			si[1][1] = quot(s00, det);
			si[0][1] = sub(0, quot(s01, det));
			si[1][0] = sub(0, quot(s10, det));
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 2; j++)
					k[i][j] = dot2(pp[i][0], si[0][j], pp[i][1], si[1][j]);
			ix = sub(mx, xp);
			iy = sub(my, yp);
			px = add(xp, dot2(k[0][0], ix, k[0][1], iy));
			py = add(yp, dot2(k[1][0], ix, k[1][1], iy));
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					ikh[i][j] = sub((i == j) ? kpt_pkg::Q_ONE : '0, (j < 2) ? k[i][j] : '0);
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					cov[i][j] = dot3(ikh[i][0], pp[0][j], ikh[i][1], pp[1][j],
						ikh[i][2], pp[2][j]);
			r.est_x = px;
			r.est_y = py;
			pending.push_back(r);
		endfunction

		function void check_estimate(fix_t got);
			fix_t want;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected estimate x=%h y=%h", got.est_x, got.est_y);
				return;
			end
			want = pending.pop_front();
			if (got.est_x !== want.est_x || got.est_y !== want.est_y) begin
				mismatches++;
				if (mismatches <= 10)
					$display("estimate %0d: want x=%h y=%h got x=%h y=%h", checked,
						want.est_x, want.est_y, got.est_x, got.est_y);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [63:0] m_axis_tdata;
	logic cfg_we = 0;
	logic [kpt_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [30:0] cfg_data = '0;

	tracker_scoreboard sb;
	longint cycles = 0;
	int fixes_sent = 0;
	int writes_done = 0;

	kalman_position_tracker uut (.*);

	always #5 clk = ~clk;

	// Stop a hung run: the limit covers every fix plus gaps and stalls many times over.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: check each accepted estimate, stall randomly between them.
	initial begin : receiver
		int gap;
		wait (arst_n);
		forever begin
			gap = $urandom_range(0, 3);
			if (gap != 0) begin
				m_axis_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			sb.check_estimate(m_axis_tdata);
		end
	end

	// Hold one request until accepted, after a random gap.
	task automatic send_fix(logic [30:0] dt, q_t mx, q_t my);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {1'b0, my, mx, dt};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_fix(dt, mx, my);
		fixes_sent++;
	endtask

	// Drain outstanding estimates, then write a register while idle.
	task automatic write_setting(logic [kpt_pkg::CFG_IDX_W-1:0] idx, logic [30:0] val);
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, val);
		writes_done++;
	endtask

	function automatic q_t rand_pos();
		case ($urandom_range(0, 5))
			0: return q_t'($urandom());
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return q_t'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
		endcase
	endfunction

	function automatic logic [30:0] rand_dt();
		case ($urandom_range(0, 7))
			0: return 31'($urandom());
			1: return 31'd0;
			default: return 31'($urandom_range(1, 2 << 16));
		endcase
	endfunction

	function automatic logic [30:0] rand_setting();
		case ($urandom_range(0, 4))
			0: return 31'd0;
			1: return 31'h7fffffff;
			2: return 31'($urandom());
			default: return 31'($urandom_range(0, 20 << 16));
		endcase
	endfunction

	initial begin : stimulus
		q_t x, y;
		sb = new();
		sb.clear();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: seeding, field extremes, zero dt, saturation.
		send_fix(31'd65536, 32'sd1 << 16, 32'sd2 << 16);
		send_fix(31'd0, 32'sh7fffffff, 32'sh80000000);
		send_fix(31'h7fffffff, 32'sh80000000, 32'sh7fffffff);
		send_fix(31'h7fffffff, 32'shffffffff, 32'sh0);
		send_fix(31'h55555555, 32'sh55555555, 32'shaaaaaaaa);
		send_fix(31'h2aaaaaaa, 32'shaaaaaaaa, 32'sh55555555);
		// Zero noise everywhere with zero speed drives toward a singular S.
		write_setting(kpt_pkg::CFG_SPEED, 31'd0);
		write_setting(kpt_pkg::CFG_POS_NOISE, 31'd0);
		write_setting(kpt_pkg::CFG_HEAD_NOISE, 31'd0);
		write_setting(kpt_pkg::CFG_MEAS_NOISE, 31'd0);
		for (int i = 0; i < 6; i++) send_fix(31'd0, 32'sd0, 32'sd0);
		write_setting(kpt_pkg::CFG_SPEED, 31'h7fffffff);
		write_setting(kpt_pkg::CFG_POS_NOISE, 31'h7fffffff);
		write_setting(kpt_pkg::CFG_HEAD_NOISE, 31'h7fffffff);
		write_setting(kpt_pkg::CFG_MEAS_NOISE, 31'h7fffffff);
		for (int i = 0; i < 6; i++) send_fix(rand_dt(), rand_pos(), rand_pos());

		// Random phases, mostly with fresh random settings; restore defaults at times.
		for (int phase = 0; phase < 20; phase++) begin
			if (phase % 5 == 0) begin
				write_setting(kpt_pkg::CFG_SPEED, 31'd3277);
				write_setting(kpt_pkg::CFG_POS_NOISE, 31'd6554);
				write_setting(kpt_pkg::CFG_HEAD_NOISE, 31'd3277);
				write_setting(kpt_pkg::CFG_MEAS_NOISE, 31'd655360);
			end else begin
				for (int r = 0; r < 4; r++)
					if ($urandom_range(0, 1))
						write_setting(kpt_pkg::CFG_IDX_W'(r), rand_setting());
			end
			// Mostly a smooth track with noise, occasionally wild fixes.
			x = rand_pos();
			y = rand_pos();
			for (int i = 0; i < 46; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_fix(rand_dt(), rand_pos(), rand_pos());
				end else begin
					x = sb.add(x, q_t'($signed($urandom_range(0, 1 << 17)) - (1 << 16)));
					y = sb.add(y, q_t'($signed($urandom_range(0, 1 << 17)) - (1 << 16)));
					send_fix(31'($urandom_range(0, 1 << 17)), x, y);
				end
			end
		end
		s_axis_tvalid <= 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		$display("Sent %0d position fixes and %0d register writes; checked %0d estimates.",
			fixes_sent, writes_done, sb.checked);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
